@@ sv/masked_byte_pattern_scanner_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the masked byte pattern scanner
// Shared helpers that wrap concurrent assertions with clock and reset.
// ----------------------------------------------------------------------------
`ifndef MASKED_BYTE_PATTERN_SCANNER_TOP_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SCANNER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MBPS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MBPS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/mbps_pkg.sv @@
// ----------------------------------------------------------------------------
// mbps_pkg
// Types and constants shared by the masked byte pattern scanner modules.
// ----------------------------------------------------------------------------
package mbps_pkg;

  localparam int MAX_PATTERN_DEF = 32;
  localparam int SIG_BYTES       = 32;
  localparam int CFG_LEN_W       = 6;

  localparam int APB_ADDR_W  = 6;
  localparam int APB_DATA_W  = 64;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 72;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [CFG_LEN_W-1:0] LEN_RESET = CFG_LEN_W'(1);

  typedef enum logic [2:0] {
    REG_PATTERN_0,
    REG_PATTERN_1,
    REG_PATTERN_2,
    REG_PATTERN_3,
    REG_WILDCARD,
    REG_LENGTH,
    REG_FIND_ALL,
    REG_BASE_OFFSET
  } reg_idx_e;

  typedef struct packed {
    logic [3:0][63:0]       pattern_word;
    logic [31:0]            wildcard_mask;
    logic [CFG_LEN_W-1:0]   pattern_length;
    logic                   find_all;
    logic [31:0]            base_offset;
  } cfg_t;

  // One queued descriptor: what a single input byte has to report.
  typedef struct packed {
    logic        match_v;
    logic        end_v;
    logic [31:0] start;
    logic [31:0] count;
  } entry_t;

endpackage

@@ sv/mbps_front.sv @@
// ----------------------------------------------------------------------------
// mbps_front
// Accepts bytes, shifts the window, compares it with the signature and
// queues a descriptor for every byte that causes a report.
// ----------------------------------------------------------------------------
module mbps_front #(
  parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  mbps_pkg::cfg_t                     cfg_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [7:0]                         data_byte_i,
  input  logic                               region_end_i,
  input  logic                               q_full_i,
  output logic                               q_push_o,
  output mbps_pkg::entry_t                   q_entry_o
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  logic [7:0]       window_q [MAX_PATTERN];
  logic [7:0]       win_d    [MAX_PATTERN];
  logic [31:0]      pos_q;
  logic [31:0]      seen_q;
  logic [LEN_W-1:0] len_eff;
  logic [LEN_W-1:0] lane_sel [MAX_PATTERN];
  logic [31:0]      lane_sel32 [MAX_PATTERN];
  logic [7:0]       lane_sig [MAX_PATTERN];
  logic             lane_wild [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] lane_ok;
  logic [32:0]      pos_p1;
  logic             in_fire;
  logic             hit;
  logic             report;
  logic [31:0]      count;

  assign in_ready_o = !q_full_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    if (cfg_i.pattern_length == '0) begin
      len_eff = LEN_W'(1);
    end else if ((mbps_pkg::CFG_LEN_W + 1)'(cfg_i.pattern_length) >
                 (mbps_pkg::CFG_LEN_W + 1)'(MAX_PATTERN)) begin
      len_eff = LEN_W'(MAX_PATTERN);
    end else begin
      len_eff = LEN_W'(cfg_i.pattern_length);
    end
  end

  // The window as it stands once the new byte has entered; entry 0 is newest.
  always_comb begin
    win_d[0] = data_byte_i;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      win_d[k] = window_q[k-1];
    end
  end

  // Window entry j lines up with signature byte len-1-j. Lanes at or beyond
  // the pattern length always pass.
  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      lane_sel[j]   = len_eff - LEN_W'(1) - LEN_W'(j);
      lane_sel32[j] = 32'(lane_sel[j]);
      lane_sig[j]   = 8'h00;
      lane_wild[j]  = 1'b0;
      if (lane_sel32[j] < 32'(mbps_pkg::SIG_BYTES)) begin
        lane_sig[j]  = cfg_i.pattern_word[lane_sel32[j][4:3]][{lane_sel32[j][2:0], 3'b000} +: 8];
        lane_wild[j] = cfg_i.wildcard_mask[lane_sel32[j][4:0]];
      end
      lane_ok[j] = (LEN_W'(j) >= len_eff) || lane_wild[j] || (lane_sig[j] == win_d[j]);
    end
  end

  assign pos_p1 = {1'b0, pos_q} + 33'd1;
  assign hit    = (pos_p1 >= 33'(len_eff)) && (&lane_ok);
  assign report = hit && (cfg_i.find_all || (seen_q == '0));
  assign count  = (report && !(&seen_q)) ? seen_q + 32'd1 : seen_q;

  assign q_push_o          = in_fire && (report || region_end_i);
  assign q_entry_o.match_v = report;
  assign q_entry_o.end_v   = region_end_i;
  assign q_entry_o.start   = pos_p1[31:0] - 32'(len_eff);
  assign q_entry_o.count   = count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      seen_q <= '0;
      for (int k = 0; k < MAX_PATTERN; k++) begin
        window_q[k] <= '0;
      end
    end else if (in_fire) begin
      if (region_end_i) begin
        pos_q  <= '0;
        seen_q <= '0;
        for (int k = 0; k < MAX_PATTERN; k++) begin
          window_q[k] <= '0;
        end
      end else begin
        pos_q  <= pos_p1[31:0];
        seen_q <= count;
        for (int k = 0; k < MAX_PATTERN; k++) begin
          window_q[k] <= win_d[k];
        end
      end
    end
  end

endmodule

@@ sv/mbps_fifo.sv @@
// ----------------------------------------------------------------------------
// mbps_fifo
// Small descriptor queue between the scanning front and the output back.
// ----------------------------------------------------------------------------
module mbps_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mbps_pkg::entry_t push_entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             head_valid_o,
  output mbps_pkg::entry_t head_entry_o
);

  mbps_pkg::entry_t               mem_q [mbps_pkg::Q_DEPTH];
  logic [mbps_pkg::Q_PTR_W-1:0]   wr_ptr_q;
  logic [mbps_pkg::Q_PTR_W-1:0]   rd_ptr_q;
  logic [mbps_pkg::Q_CNT_W-1:0]   cnt_q;
  logic                           do_pop;

  assign full_o       = (cnt_q == mbps_pkg::Q_CNT_W'(mbps_pkg::Q_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_entry_o = mem_q[rd_ptr_q];
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + mbps_pkg::Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + mbps_pkg::Q_PTR_W'(1);
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + mbps_pkg::Q_CNT_W'(1);
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - mbps_pkg::Q_CNT_W'(1);
      end
    end
  end

endmodule

@@ sv/mbps_back.sv @@
// ----------------------------------------------------------------------------
// mbps_back
// Expands each queued descriptor into one or two result words and holds
// them in the output register until the receiver takes them.
// ----------------------------------------------------------------------------
module mbps_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mbps_pkg::cfg_t                      cfg_i,
  input  logic                                head_valid_i,
  input  mbps_pkg::entry_t                    head_entry_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [mbps_pkg::OUT_TDATA_W-1:0]    out_data_o,
  output logic                                out_user_o,
  output logic                                out_last_o
);

  typedef enum logic {
    PH_FIRST,
    PH_END
  } phase_e;

  phase_e      phase_q;
  phase_e      phase_d;
  logic        valid_q;
  logic [mbps_pkg::OUT_TDATA_W-1:0] data_q;
  logic        user_q;
  logic        last_q;
  logic        load;
  logic        emit_match;
  logic        take_head;
  logic [31:0] offset;
  logic        found;
  logic        word_last;

  assign load       = head_valid_i && (!valid_q || out_ready_i);
  assign emit_match = head_entry_i.match_v && (phase_q == PH_FIRST);

  always_comb begin
    if (emit_match) begin
      offset    = cfg_i.base_offset + head_entry_i.start;
      found     = 1'b1;
      word_last = !head_entry_i.end_v;
      take_head = !head_entry_i.end_v;
      phase_d   = head_entry_i.end_v ? PH_END : PH_FIRST;
    end else begin
      offset    = '0;
      found     = (head_entry_i.count != '0);
      word_last = 1'b1;
      take_head = 1'b1;
      phase_d   = PH_FIRST;
    end
  end

  assign pop_o = load && take_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= PH_FIRST;
      data_q  <= '0;
      user_q  <= 1'b0;
      last_q  <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
      phase_q <= phase_d;
      data_q  <= {7'b0, head_entry_i.count, found, offset};
      user_q  <= emit_match;
      last_q  <= word_last;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_user_o  = user_q;
  assign out_last_o  = last_q;

endmodule

@@ sv/masked_byte_pattern_scanner_top.sv @@
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner_top
// Masked byte signature scanner with a stream input, a stream output and
// an APB register port.
// ----------------------------------------------------------------------------
// Usage: bytes of a region enter on the s_axis channel, one word per byte,
// with s_axis_tlast on the last byte. Each byte that completes a signature
// match lying wholly inside the region yields a match word (tuser 1) with
// base_offset plus the match start; without find_all, only the first match
// of a region does. The last byte also yields an end word (tuser 0) with the
// found flag and the match count, after any match word. m_axis_tlast marks
// the final word caused by a byte. Throughput: one byte per cycle while the
// descriptor queue is not full; window bytes are compared in parallel lanes.
// A byte with both a match and an end report yields two words. Results pass
// through the queue into the output register, which moves one word per cycle
// while the receiver is ready. When it stalls, the output word holds and the
// two-entry queue fills; s_axis_tready drops only when that queue is full.
// Reset clears the window, position, count, queue and output register, and
// loads register defaults (pattern length 1, all else zero). No clearing
// pass is needed. Write registers only while no results are outstanding.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner_top #(
  parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // APB register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mbps_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [mbps_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [mbps_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  // Input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [mbps_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [7:0] data_byte
  input  logic                                s_axis_tlast,  // region_end
  // Output stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [31:0] match_offset, [32] found_any, [64:33] match_count, [71:65] zero
  output logic [mbps_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                                m_axis_tuser,  // is_match
  output logic                                m_axis_tlast   // last_result
);

  mbps_pkg::cfg_t     cfg_q;
  mbps_pkg::reg_idx_e reg_idx;
  logic               wr_en;
  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               head_valid;
  mbps_pkg::entry_t   push_entry;
  mbps_pkg::entry_t   head_entry;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = mbps_pkg::reg_idx_e'(paddr[mbps_pkg::APB_ADDR_W-1:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern_word   <= '0;
      cfg_q.wildcard_mask  <= '0;
      cfg_q.pattern_length <= mbps_pkg::LEN_RESET;
      cfg_q.find_all       <= 1'b0;
      cfg_q.base_offset    <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        mbps_pkg::REG_PATTERN_0:   cfg_q.pattern_word[0] <= pwdata;
        mbps_pkg::REG_PATTERN_1:   cfg_q.pattern_word[1] <= pwdata;
        mbps_pkg::REG_PATTERN_2:   cfg_q.pattern_word[2] <= pwdata;
        mbps_pkg::REG_PATTERN_3:   cfg_q.pattern_word[3] <= pwdata;
        mbps_pkg::REG_WILDCARD:    cfg_q.wildcard_mask   <= pwdata[31:0];
        mbps_pkg::REG_LENGTH:      cfg_q.pattern_length  <= pwdata[mbps_pkg::CFG_LEN_W-1:0];
        mbps_pkg::REG_FIND_ALL:    cfg_q.find_all        <= pwdata[0];
        mbps_pkg::REG_BASE_OFFSET: cfg_q.base_offset     <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mbps_pkg::REG_PATTERN_0:   prdata = cfg_q.pattern_word[0];
      mbps_pkg::REG_PATTERN_1:   prdata = cfg_q.pattern_word[1];
      mbps_pkg::REG_PATTERN_2:   prdata = cfg_q.pattern_word[2];
      mbps_pkg::REG_PATTERN_3:   prdata = cfg_q.pattern_word[3];
      mbps_pkg::REG_WILDCARD:    prdata = mbps_pkg::APB_DATA_W'(cfg_q.wildcard_mask);
      mbps_pkg::REG_LENGTH:      prdata = mbps_pkg::APB_DATA_W'(cfg_q.pattern_length);
      mbps_pkg::REG_FIND_ALL:    prdata = mbps_pkg::APB_DATA_W'(cfg_q.find_all);
      mbps_pkg::REG_BASE_OFFSET: prdata = mbps_pkg::APB_DATA_W'(cfg_q.base_offset);
      default:                   prdata = '0;
    endcase
  end

  mbps_front #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .data_byte_i  (s_axis_tdata[7:0]),
    .region_end_i (s_axis_tlast),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_entry_o    (push_entry)
  );

  mbps_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_valid_o (head_valid),
    .head_entry_o (head_entry)
  );

  mbps_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_entry_i (head_entry),
    .pop_o        (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_user_o   (m_axis_tuser),
    .out_last_o   (m_axis_tlast)
  );

endmodule

@@ sv/mbps_checker.sv @@
// ----------------------------------------------------------------------------
// mbps_checker
// Port-level checks on the result stream of the scanner, bound to the top.
// ----------------------------------------------------------------------------
`include "masked_byte_pattern_scanner_top_defines.svh"

module mbps_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [mbps_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tuser,
  input logic                             m_axis_tlast
);

  // A stalled word stays put.
  `MBPS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled output word changed")

  // An end word closes the byte, carries no offset and a consistent found flag.
  `MBPS_ASSERT_IMP(a_end_word, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser, m_axis_tlast && (m_axis_tdata[31:0] == 32'd0) && (m_axis_tdata[32] == (m_axis_tdata[64:33] != 32'd0)), "malformed end word")

  // A match word always reports found and a nonzero count.
  `MBPS_ASSERT_IMP(a_match_word, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tdata[32] && (m_axis_tdata[64:33] != 32'd0), "malformed match word")

  // A match word that is not final is followed directly by its end word.
  `MBPS_ASSERT_NXT(a_end_follows, clk_i, rst_ni, m_axis_tvalid && m_axis_tready && m_axis_tuser && !m_axis_tlast, m_axis_tvalid && !m_axis_tuser && m_axis_tlast, "end word did not follow match word")

endmodule

bind masked_byte_pattern_scanner_top mbps_checker u_mbps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
